FILE: hdl/fpa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fixed-point ALU package
// Opcodes and shared widths for the fixed-point ALU.
// ----------------------------------------------------------------------------
package fpa_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned OP_W   = 4;

  typedef enum logic [OP_W-1:0] {
    OP_ADD      = 4'd0,
    OP_SUB      = 4'd1,
    OP_MUL      = 4'd2,
    OP_DIV      = 4'd3,
    OP_GT       = 4'd4,
    OP_LT       = 4'd5,
    OP_GE       = 4'd6,
    OP_LE       = 4'd7,
    OP_EQ       = 4'd8,
    OP_NE       = 4'd9,
    OP_MIN      = 4'd10,
    OP_MAX      = 4'd11,
    OP_INC      = 4'd12,
    OP_DEC      = 4'd13,
    OP_TO_INT   = 4'd14,
    OP_FROM_INT = 4'd15
  } op_e;

  typedef logic signed [WORD_W-1:0] word_t;

endpackage

FILE: hdl/fpa_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fixed-point ALU channels
// Request channel (opcode, operands) and response channel (word, flags).
// ----------------------------------------------------------------------------
interface fpa_req_if;
  import fpa_pkg::*;

  logic  valid;
  logic  ready;
  op_e   opcode;
  word_t operand_a;
  word_t operand_b;

  modport source (output valid, output opcode, output operand_a, output operand_b,
                  input ready);
  modport sink   (input valid, input opcode, input operand_a, input operand_b,
                  output ready);
endinterface

interface fpa_rsp_if;
  import fpa_pkg::*;

  logic  valid;
  logic  ready;
  word_t result_word;
  logic  compare_true;
  logic  divide_by_zero;

  modport source (output valid, output result_word, output compare_true,
                  output divide_by_zero, input ready);
  modport sink   (input valid, input result_word, input compare_true,
                  input divide_by_zero, output ready);
endinterface

FILE: hdl/fixed_point_alu_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fixed-point ALU core
// Pipelined ALU for signed 32-bit words with FRAC_BITS fraction bits.
// ----------------------------------------------------------------------------
// Usage:
//   req_i carries opcode, operand_a, operand_b; rsp_o returns result_word,
//   compare_true and divide_by_zero, one response per request, in order.
//   A request is taken on an edge with valid and ready high.
// Path: every opcode passes the input register, the setup stage, the divide
//   stages and the output register; the depth is set by the divider, which
//   retires one quotient bit per stage over 32 + FRAC_BITS stages.
// Throughput: one request per cycle while the receiver takes responses.
// Stall: when a response waits and rsp_o.ready is low, the whole pipeline
//   holds and req_i.ready drops; nothing is lost or repeated.
// Reset: asynchronous, clears all valid bits; the pipeline starts empty.
// Multiply keeps the 64-bit product and shifts right by FRAC_BITS (floor).
// Divide pre-shifts the dividend, truncates toward zero; by zero gives 0
//   with divide_by_zero set.
// ----------------------------------------------------------------------------
module fixed_point_alu_core #(
  parameter int unsigned FRAC_BITS = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  fpa_req_if.sink    req_i,
  fpa_rsp_if.source  rsp_o
);
  import fpa_pkg::*;

  localparam int unsigned NUM_W = WORD_W + FRAC_BITS;
  localparam int unsigned ACC_W = NUM_W + 33;
  localparam int unsigned STEPS = NUM_W;

  logic en;

  // input register
  logic  v0_q;
  op_e   op0_q;
  word_t a0_q, b0_q;

  // pipeline, index 0 is the setup stage, index k after k divide steps
  logic                    pv_q   [0:STEPS];
  op_e                     pop_q  [0:STEPS];
  word_t                   pw_q   [0:STEPS];
  logic                    pcmp_q [0:STEPS];
  logic                    pdz_q  [0:STEPS];
  logic                    pneg_q [0:STEPS];
  logic [ACC_W-1:0]        pacc_q [0:STEPS];
  logic [32:0]             pdiv_q [0:STEPS];
  logic signed [63:0]      prod_q;

  logic                    ov_q;
  word_t                   ow_q;
  logic                    ocmp_q, odz_q;

  assign en          = !ov_q || rsp_o.ready;
  assign req_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (en) begin
      v0_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      op0_q <= req_i.opcode;
      a0_q  <= req_i.operand_a;
      b0_q  <= req_i.operand_b;
    end
  end

  // setup stage
  word_t            w1_d;
  logic             cmp1_d;
  logic [31:0]      mag_a, mag_b;
  logic [NUM_W-1:0] num1_d;

  always_comb begin
    w1_d   = '0;
    cmp1_d = 1'b0;
    case (op0_q)
      OP_ADD:      w1_d = a0_q + b0_q;
      OP_SUB:      w1_d = a0_q - b0_q;
      OP_GT:       cmp1_d = a0_q > b0_q;
      OP_LT:       cmp1_d = a0_q < b0_q;
      OP_GE:       cmp1_d = a0_q >= b0_q;
      OP_LE:       cmp1_d = a0_q <= b0_q;
      OP_EQ:       cmp1_d = a0_q == b0_q;
      OP_NE:       cmp1_d = a0_q != b0_q;
      OP_MIN:      w1_d = (a0_q > b0_q) ? b0_q : a0_q;
      OP_MAX:      w1_d = (a0_q < b0_q) ? b0_q : a0_q;
      OP_INC:      w1_d = a0_q + 32'sd1;
      OP_DEC:      w1_d = a0_q - 32'sd1;
      OP_TO_INT:   w1_d = a0_q >>> FRAC_BITS;
      OP_FROM_INT: w1_d = a0_q <<< FRAC_BITS;
      default:     w1_d = '0;
    endcase
    mag_a  = a0_q[31] ? (32'd0 - a0_q) : a0_q;
    mag_b  = b0_q[31] ? (32'd0 - b0_q) : b0_q;
    num1_d = NUM_W'(mag_a) << FRAC_BITS;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q[0] <= 1'b0;
    end else if (en) begin
      pv_q[0] <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pop_q[0]  <= op0_q;
      pw_q[0]   <= w1_d;
      pcmp_q[0] <= cmp1_d;
      pdz_q[0]  <= (op0_q == OP_DIV) && (b0_q == '0);
      pneg_q[0] <= a0_q[31] ^ b0_q[31];
      pacc_q[0] <= {33'd0, num1_d};
      pdiv_q[0] <= {1'b0, mag_b};
      prod_q    <= 64'(a0_q) * 64'(b0_q);
    end
  end

  // divide steps
  for (genvar k = 1; k <= STEPS; k++) begin : g_step
    logic [ACC_W-1:0] acc_d;
    word_t            w_d;

    fpa_div_step #(.NUM_W(NUM_W)) u_step (
      .acc_i (pacc_q[k-1]),
      .div_i (pdiv_q[k-1]),
      .acc_o (acc_d)
    );

    if (k == 1) begin : g_mul
      logic signed [63:0] prod_sh;
      assign prod_sh = prod_q >>> FRAC_BITS;
      assign w_d = (pop_q[0] == OP_MUL) ? word_t'(prod_sh[31:0]) : pw_q[0];
    end else begin : g_pass
      assign w_d = pw_q[k-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        pv_q[k] <= 1'b0;
      end else if (en) begin
        pv_q[k] <= pv_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        pop_q[k]  <= pop_q[k-1];
        pw_q[k]   <= w_d;
        pcmp_q[k] <= pcmp_q[k-1];
        pdz_q[k]  <= pdz_q[k-1];
        pneg_q[k] <= pneg_q[k-1];
        pacc_q[k] <= acc_d;
        pdiv_q[k] <= pdiv_q[k-1];
      end
    end
  end

  // output register
  logic [31:0] quo;
  word_t       ow_d;

  always_comb begin
    quo = pacc_q[STEPS][31:0];
    if (pop_q[STEPS] == OP_DIV) begin
      if (pdz_q[STEPS]) begin
        ow_d = '0;
      end else begin
        ow_d = pneg_q[STEPS] ? word_t'(32'd0 - quo) : word_t'(quo);
      end
    end else begin
      ow_d = pw_q[STEPS];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (en) begin
      ov_q <= pv_q[STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ow_q   <= ow_d;
      ocmp_q <= pcmp_q[STEPS];
      odz_q  <= pdz_q[STEPS];
    end
  end

  assign rsp_o.valid          = ov_q;
  assign rsp_o.result_word    = ow_q;
  assign rsp_o.compare_true   = ocmp_q;
  assign rsp_o.divide_by_zero = odz_q;

  a_dz_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && odz_q |-> ow_q == '0)
    else $error("divide by zero with nonzero word");

  a_flags_excl : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q |-> !(ocmp_q && odz_q))
    else $error("compare and divide flags both set");

  a_cmp_word : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && ocmp_q |-> ow_q == '0)
    else $error("comparison with nonzero word");

  a_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(pv_q[STEPS]) && $stable(v0_q))
    else $error("pipeline moved while stalled");

endmodule

FILE: hdl/fpa_div_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Divider step
// One restoring step: shift remainder/quotient, subtract divisor if it fits.
// ----------------------------------------------------------------------------
module fpa_div_step #(
  parameter int unsigned NUM_W = 40
) (
  input  logic [NUM_W+32:0] acc_i,
  input  logic [32:0]       div_i,
  output logic [NUM_W+32:0] acc_o
);
  localparam int unsigned ACC_W = NUM_W + 33;

  logic [ACC_W-1:0] sh;
  logic [32:0]      rem;
  logic [33:0]      diff;

  always_comb begin
    sh   = {acc_i[ACC_W-2:0], 1'b0};
    rem  = sh[ACC_W-1:NUM_W];
    diff = {1'b0, rem} - {1'b0, div_i};
    if (!diff[33]) begin
      acc_o = {diff[32:0], sh[NUM_W-1:1], 1'b1};
    end else begin
      acc_o = sh;
    end
  end
endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fixed-point ALU testbench
// Drives opcode/operand requests with random gaps, predicts each response
// with a local Q-format model or a directed entry, checks in order, field by field.
// ----------------------------------------------------------------------------
module tb;
  import fpa_pkg::*;

  localparam int unsigned FRAC = 8;
  localparam int unsigned N_RANDOM = 1000;
  localparam int unsigned STALL_LIMIT = 2000;

  typedef struct packed {
    word_t word;
    logic  cmp;
    logic  dz;
  } alu_out_t;

  typedef struct {
    op_e      op;
    word_t    a;
    word_t    b;
    bit       typed;
    alu_out_t res;
  } vec_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  fpa_req_if req_if ();
  fpa_rsp_if rsp_if ();

  fixed_point_alu_core #(.FRAC_BITS(FRAC)) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if.sink),
    .rsp_o (rsp_if.source)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  alu_out_t pending_q[$];
  int       n_err = 0;
  int       idle_cycles = 0;
  bit       stim_done = 1'b0;

  function automatic alu_out_t alu_predict(op_e op, word_t a, word_t b);
    alu_out_t       r;
    logic signed [63:0] wa;
    logic signed [63:0] wb;
    logic signed [63:0] p;
    wa = a;
    wb = b;
    r = '0;
    case (op)
      OP_ADD:      r.word = a + b;
      OP_SUB:      r.word = a - b;
      OP_MUL: begin
        p = (wa * wb) >>> FRAC;
        r.word = p[31:0];
      end
      OP_DIV: begin
        if (b == 0) begin
          r.dz = 1'b1;
        end else begin
          p = (wa <<< FRAC) / wb;
          r.word = p[31:0];
        end
      end
      OP_GT:       r.cmp = a > b;
      OP_LT:       r.cmp = a < b;
      OP_GE:       r.cmp = a >= b;
      OP_LE:       r.cmp = a <= b;
      OP_EQ:       r.cmp = a == b;
      OP_NE:       r.cmp = a != b;
      OP_MIN:      r.word = (a > b) ? b : a;
      OP_MAX:      r.word = (a < b) ? b : a;
      OP_INC:      r.word = a + 32'sd1;
      OP_DEC:      r.word = a - 32'sd1;
      OP_TO_INT:   r.word = a >>> FRAC;
      default:     r.word = a << FRAC;
    endcase
    return r;
  endfunction

  function automatic word_t rand_word();
    case ($urandom_range(0, 5))
      0:       return word_t'($urandom_range(0, 8)) - 4;
      1:       return 32'sh7fff_ffff - word_t'($urandom_range(0, 2));
      2:       return 32'sh8000_0000 + word_t'($urandom_range(0, 2));
      3:       return word_t'($urandom_range(0, 32'h0002_0000)) - 32'sh0001_0000;
      default: return word_t'($urandom());
    endcase
  endfunction

  task automatic send_request(op_e op, word_t a, word_t b, bit typed, alu_out_t res);
    alu_out_t    exp_r;
    int unsigned gap;
    gap = $urandom_range(0, 12);
    exp_r = typed ? res : alu_predict(op, a, b);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_if.opcode    <= op;
    req_if.operand_a <= a;
    req_if.operand_b <= b;
    req_if.valid     <= 1'b1;
    do @(posedge clk_i); while (!req_if.ready);
    pending_q.push_back(exp_r);
    @(negedge clk_i);
  endtask

  // Response side: random back-pressure, in-order check.
  always @(posedge clk_i) begin
    alu_out_t e;
    if (rsp_if.valid && rsp_if.ready) begin
      if (pending_q.size() == 0) begin
        n_err++;
        if (n_err <= 10) $display("unexpected response word=%h", rsp_if.result_word);
      end else begin
        e = pending_q.pop_front();
        if (rsp_if.result_word !== e.word || rsp_if.compare_true !== e.cmp ||
            rsp_if.divide_by_zero !== e.dz) begin
          n_err++;
          if (n_err <= 10)
            $display("mismatch: exp word=%h cmp=%b dz=%b, got word=%h cmp=%b dz=%b",
                     e.word, e.cmp, e.dz, rsp_if.result_word,
                     rsp_if.compare_true, rsp_if.divide_by_zero);
        end
      end
    end
  end

  int rsp_wait = 0;
  always @(negedge clk_i) begin
    if (rsp_if.ready && rsp_if.valid) rsp_wait = $urandom_range(0, 3) == 0 ?
                                                 0 : $urandom_range(0, 12);
    if (rsp_wait > 0) begin
      rsp_wait--;
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= 1'b1;
    end
  end

  // Watchdog on cycles without any accepted request or response.
  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) idle_cycles = 0;
    else if (!stim_done || pending_q.size() != 0) idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  vec_t dir_tbl[$];

  task automatic add_vec(op_e op, word_t a, word_t b, bit typed, word_t w, logic c, logic d);
    vec_t v;
    v.op = op;
    v.a = a;
    v.b = b;
    v.typed = typed;
    v.res = '{word: w, cmp: c, dz: d};
    dir_tbl.push_back(v);
  endtask

  initial begin
    op_e op;
    word_t max_w;
    word_t min_w;
    max_w = 32'sh7fff_ffff;
    min_w = 32'sh8000_0000;
    req_if.valid = 1'b0;
    req_if.opcode = OP_ADD;
    req_if.operand_a = '0;
    req_if.operand_b = '0;
    rsp_if.ready = 1'b0;

    add_vec(OP_ADD, max_w, 32'sd1, 1'b1, min_w, 1'b0, 1'b0);
    add_vec(OP_SUB, min_w, 32'sd1, 1'b1, max_w, 1'b0, 1'b0);
    add_vec(OP_MUL, 32'sd512, 32'sd768, 1'b1, 32'sd1536, 1'b0, 1'b0);
    add_vec(OP_MUL, -32'sd1, 32'sd1, 1'b1, -32'sd1, 1'b0, 1'b0);
    add_vec(OP_MUL, max_w, max_w, 1'b0, '0, 1'b0, 1'b0);
    add_vec(OP_MUL, min_w, min_w, 1'b0, '0, 1'b0, 1'b0);
    add_vec(OP_DIV, 32'sd1234, 32'sd0, 1'b1, '0, 1'b0, 1'b1);
    add_vec(OP_DIV, min_w, 32'sd0, 1'b1, '0, 1'b0, 1'b1);
    add_vec(OP_DIV, min_w, -32'sd1, 1'b0, '0, 1'b0, 1'b0);
    add_vec(OP_DIV, -32'sd256, 32'sd768, 1'b0, '0, 1'b0, 1'b0);
    add_vec(OP_DIV, max_w, 32'sd1, 1'b0, '0, 1'b0, 1'b0);
    add_vec(OP_GT, max_w, min_w, 1'b1, '0, 1'b1, 1'b0);
    add_vec(OP_LT, max_w, min_w, 1'b1, '0, 1'b0, 1'b0);
    add_vec(OP_GE, 32'sd5, 32'sd5, 1'b1, '0, 1'b1, 1'b0);
    add_vec(OP_LE, min_w, max_w, 1'b1, '0, 1'b1, 1'b0);
    add_vec(OP_EQ, -32'sd1, -32'sd1, 1'b1, '0, 1'b1, 1'b0);
    add_vec(OP_NE, -32'sd1, -32'sd1, 1'b1, '0, 1'b0, 1'b0);
    add_vec(OP_MIN, min_w, max_w, 1'b1, min_w, 1'b0, 1'b0);
    add_vec(OP_MAX, min_w, max_w, 1'b1, max_w, 1'b0, 1'b0);
    add_vec(OP_INC, max_w, '0, 1'b1, min_w, 1'b0, 1'b0);
    add_vec(OP_DEC, min_w, '0, 1'b1, max_w, 1'b0, 1'b0);
    add_vec(OP_TO_INT, -32'sd1, '0, 1'b1, -32'sd1, 1'b0, 1'b0);
    add_vec(OP_TO_INT, max_w, '0, 1'b1, 32'sh007f_ffff, 1'b0, 1'b0);
    add_vec(OP_FROM_INT, max_w, '0, 1'b1, 32'shffff_ff00, 1'b0, 1'b0);
    add_vec(OP_FROM_INT, min_w, -32'sd1, 1'b1, '0, 1'b0, 1'b0);

    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_tbl[i])
      send_request(dir_tbl[i].op, dir_tbl[i].a, dir_tbl[i].b, dir_tbl[i].typed,
                   dir_tbl[i].res);
    for (int n = 0; n < N_RANDOM; n++) begin
      op = op_e'($urandom_range(0, 15));
      // Divide-by-zero and equal operands now and then.
      if (op == OP_DIV && $urandom_range(0, 9) == 0) begin
        send_request(op, rand_word(), '0, 1'b0, '0);
      end else if ($urandom_range(0, 9) == 0) begin
        max_w = rand_word();
        send_request(op, max_w, max_w, 1'b0, '0);
      end else begin
        send_request(op, rand_word(), rand_word(), 1'b0, '0);
      end
    end
    req_if.valid <= 1'b0;
    stim_done = 1'b1;

    wait (pending_q.size() == 0);
    repeat (50) @(posedge clk_i);
    if (n_err == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
